// File: rtl/tramon_pkg.sv
// Package with the shared types and constants of the traffic rate activity monitor.
`timescale 1ns / 1ps
`default_nettype none

package tramon_pkg;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned BYTES_W   = 31;
  localparam int unsigned TOTAL_W   = 64;
  localparam int unsigned SPEED_W   = 31;
  localparam int unsigned REQ_OUT_W = 8;
  localparam int unsigned BOOST_W   = 5;
  localparam int unsigned PERIOD_W  = 12;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [PERIOD_W-1:0] BASE_PERIOD_RST = 12'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_RECV      = 3'd0,
    CMD_SEND      = 3'd1,
    CMD_REQ_START = 3'd2,
    CMD_REQ_END   = 3'd3,
    CMD_TICK      = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MONITOR_ENABLED = 1'd0,
    REG_BASE_PERIOD_MS  = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [BYTES_W-1:0] byte_count;
    logic               notify_accepted;
  } item_t;

  typedef struct packed {
    logic                 notify;
    logic                 transfer_active;
    logic                 process_active;
    logic [TOTAL_W-1:0]   recv_total;
    logic [TOTAL_W-1:0]   sent_total;
    logic [SPEED_W-1:0]   speed;
    logic [REQ_OUT_W-1:0] requests_in_flight;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/traffic_rate_activity_monitor_unit.sv
// Top level of the traffic rate activity monitor.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_ready    cmd, byte_count, notify_accepted
//   out_     output     out_valid/out_ready  notify, flags, totals, speed, requests
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_ready stays high; an accepted input
// is captured in the input register, updated by the combinational core and then
// captured in the result register, which drives the output handshake.
// Reset is synchronous and needs no clearing pass; the block accepts input once reset
// is released. A stalled consumer fills the result register and
// then the input register, after which in_ready stays low until out_ready returns.
`timescale 1ns / 1ps
`default_nettype none

module traffic_rate_activity_monitor_unit #(
  parameter int unsigned MAX_REQUESTS = 255,
  parameter int unsigned BOOST_START  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [tramon_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tramon_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [tramon_pkg::CMD_W-1:0]        in_cmd,
  input  wire logic [tramon_pkg::BYTES_W-1:0]      in_byte_count,
  input  wire logic                                in_notify_accepted,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_notify,
  output logic                                     out_transfer_active,
  output logic                                     out_process_active,
  output logic [tramon_pkg::TOTAL_W-1:0]           out_recv_total,
  output logic [tramon_pkg::TOTAL_W-1:0]           out_sent_total,
  output logic [tramon_pkg::SPEED_W-1:0]           out_speed,
  output logic [tramon_pkg::REQ_OUT_W-1:0]         out_requests_in_flight
);

  tramon_pkg::item_t   in_item;
  tramon_pkg::item_t   item;
  tramon_pkg::result_t res;
  tramon_pkg::result_t out_res;
  logic                item_valid;
  logic                fire;

  assign in_item.cmd             = in_cmd;
  assign in_item.byte_count      = in_byte_count;
  assign in_item.notify_accepted = in_notify_accepted;

  tramon_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_take  (fire),
    .item       (item)
  );

  tramon_core #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .BOOST_START  (BOOST_START)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .result    (res)
  );

  tramon_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res_take  (fire),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_notify             = out_res.notify;
  assign out_transfer_active    = out_res.transfer_active;
  assign out_process_active     = out_res.process_active;
  assign out_recv_total         = out_res.recv_total;
  assign out_sent_total         = out_res.sent_total;
  assign out_speed              = out_res.speed;
  assign out_requests_in_flight = out_res.requests_in_flight;

endmodule

`default_nettype wire

// File: rtl/tramon_in_reg.sv
// Input register that holds one accepted transaction until the core takes it.
`timescale 1ns / 1ps
`default_nettype none

module tramon_in_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tramon_pkg::item_t in_item,
  output logic                 item_valid,
  input  wire logic            item_take,
  output tramon_pkg::item_t    item
);

  logic              vld_r;
  logic              vld_nxt;
  tramon_pkg::item_t item_r;

  assign in_ready   = !vld_r || item_take;
  assign item_valid = vld_r;
  assign item       = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (item_take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tramon_core.sv
// Monitor state, configuration registers and the per-transaction update logic.
`timescale 1ns / 1ps
`default_nettype none

module tramon_core #(
  parameter int unsigned MAX_REQUESTS = 255,
  parameter int unsigned BOOST_START  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [tramon_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tramon_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire logic                                fire,
  input  wire tramon_pkg::item_t                   item,
  output tramon_pkg::result_t                      result
);

  localparam int unsigned CNT_W   = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned TOTAL_W = tramon_pkg::TOTAL_W;
  localparam int unsigned SPEED_W = tramon_pkg::SPEED_W;
  localparam int unsigned BOOST_W = tramon_pkg::BOOST_W;
  localparam int unsigned PER_W   = tramon_pkg::PERIOD_W;
  localparam int unsigned REQ_PAD = tramon_pkg::REQ_OUT_W;

  logic               en_r;
  logic [PER_W-1:0]   base_r;

  logic [TOTAL_W-1:0] recv_r, recv_nxt;
  logic [TOTAL_W-1:0] sent_r, sent_nxt;
  // Bytes moved since the last sample, modulo 2^64.
  logic [TOTAL_W-1:0] delta_r, delta_nxt;
  logic [SPEED_W-1:0] speed_r, speed_nxt;
  logic               ft_r, ft_nxt;
  logic               fp_r, fp_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BOOST_W-1:0] boost_r, boost_nxt;
  logic               pend_r, pend_nxt;
  logic [PER_W-1:0]   tick_r, tick_nxt;

  logic [1:0]         shift;
  logic [PER_W-1:0]   period_raw;
  logic [PER_W-1:0]   period;
  logic [PER_W-1:0]   tick_inc;
  logic               sat;
  logic [SPEED_W-1:0] speed_calc;
  logic               notify;
  logic               ft_mid;
  logic               pend_mid;
  logic [BOOST_W-1:0] boost_mid;
  logic [CNT_W+REQ_PAD-1:0] cnt_ext;

  assign shift      = boost_r[BOOST_W-1:BOOST_W-2];
  assign period_raw = base_r >> shift;
  assign period     = (period_raw == '0) ? PER_W'(1) : period_raw;
  assign tick_inc   = tick_r + PER_W'(1);
  assign speed_calc = delta_r[SPEED_W-1:0] << shift;

  always_comb begin
    case (shift)
      2'd0:    sat = |delta_r[TOTAL_W-1:SPEED_W];
      2'd1:    sat = |delta_r[TOTAL_W-1:SPEED_W-1];
      2'd2:    sat = |delta_r[TOTAL_W-1:SPEED_W-2];
      2'd3:    sat = |delta_r[TOTAL_W-1:SPEED_W-3];
      default: sat = 1'b1;
    endcase
  end

  always_comb begin
    recv_nxt  = recv_r;
    sent_nxt  = sent_r;
    delta_nxt = delta_r;
    speed_nxt = speed_r;
    ft_nxt    = ft_r;
    fp_nxt    = fp_r;
    cnt_nxt   = cnt_r;
    boost_nxt = boost_r;
    pend_nxt  = pend_r;
    tick_nxt  = tick_r;
    notify    = 1'b0;
    ft_mid    = ft_r;
    pend_mid  = pend_r;
    boost_mid = boost_r;
    case (item.cmd)
      tramon_pkg::CMD_RECV: begin
        recv_nxt  = recv_r + TOTAL_W'(item.byte_count);
        delta_nxt = delta_r + TOTAL_W'(item.byte_count);
        notify    = !ft_r && en_r;
        ft_nxt    = 1'b1;
      end
      tramon_pkg::CMD_SEND: begin
        sent_nxt  = sent_r + TOTAL_W'(item.byte_count);
        delta_nxt = delta_r + TOTAL_W'(item.byte_count);
        notify    = !ft_r && en_r;
        ft_nxt    = 1'b1;
      end
      tramon_pkg::CMD_REQ_START: begin
        if (cnt_r == '0) begin
          notify = !fp_r && en_r;
          fp_nxt = 1'b1;
        end
        if (cnt_r < CNT_W'(MAX_REQUESTS)) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      tramon_pkg::CMD_REQ_END: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      tramon_pkg::CMD_TICK: begin
        tick_nxt = tick_inc;
        if (tick_inc >= period) begin
          tick_nxt  = '0;
          delta_nxt = '0;
          speed_nxt = sat ? {SPEED_W{1'b1}} : speed_calc;
          if (en_r) begin
            // Transfer is dropped first so an idle process can drop in the same sample.
            if (speed_nxt == '0 && ft_r) begin
              ft_mid   = 1'b0;
              pend_mid = 1'b1;
            end
            if (cnt_r == '0 && fp_r && !ft_mid) begin
              fp_nxt   = 1'b0;
              pend_mid = 1'b1;
            end
            if (pend_mid) begin
              notify    = 1'b1;
              boost_mid = BOOST_W'(BOOST_START);
              if (item.notify_accepted) begin
                pend_mid = 1'b0;
              end
            end
          end
          ft_nxt    = ft_mid;
          pend_nxt  = pend_mid;
          boost_nxt = (boost_mid != '0) ? boost_mid - BOOST_W'(1) : boost_mid;
        end
      end
      default: begin
        notify = 1'b0;
      end
    endcase
  end

  assign cnt_ext = {{REQ_PAD{1'b0}}, cnt_nxt};

  always_comb begin
    result.notify             = notify;
    result.transfer_active    = ft_nxt;
    result.process_active     = fp_nxt;
    result.recv_total         = recv_nxt;
    result.sent_total         = sent_nxt;
    result.speed              = speed_nxt;
    result.requests_in_flight = cnt_ext[REQ_PAD-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      base_r <= tramon_pkg::BASE_PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tramon_pkg::REG_MONITOR_ENABLED: en_r   <= cfg_wdata[0];
        tramon_pkg::REG_BASE_PERIOD_MS:  base_r <= cfg_wdata[PER_W-1:0];
        default: begin
          en_r <= en_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recv_r  <= '0;
      sent_r  <= '0;
      delta_r <= '0;
      speed_r <= '0;
      ft_r    <= 1'b0;
      fp_r    <= 1'b0;
      cnt_r   <= '0;
      boost_r <= '0;
      pend_r  <= 1'b0;
      tick_r  <= '0;
    end else if (fire) begin
      recv_r  <= recv_nxt;
      sent_r  <= sent_nxt;
      delta_r <= delta_nxt;
      speed_r <= speed_nxt;
      ft_r    <= ft_nxt;
      fp_r    <= fp_nxt;
      cnt_r   <= cnt_nxt;
      boost_r <= boost_nxt;
      pend_r  <= pend_nxt;
      tick_r  <= tick_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_REQUESTS))
    else $error("request count above its limit");

  a_process_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> fp_r)
    else $error("requests in flight without the process flag");

  a_boost_limit: assert property (@(posedge clk) disable iff (!rst_n)
    boost_r < BOOST_W'(BOOST_START))
    else $error("boost level above its start value after a sample");

  a_notify_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && result.notify) |-> en_r)
    else $error("notify posted while the monitor is disabled");

  a_delta_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.cmd == tramon_pkg::CMD_TICK && tick_nxt == '0) |=> (delta_r == '0))
    else $error("byte delta not cleared after a sample");
`endif

endmodule

`default_nettype wire

// File: rtl/tramon_out_reg.sv
// Result register that holds one finished transaction until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none

module tramon_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                res_valid,
  output logic                     res_take,
  input  wire tramon_pkg::result_t res,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tramon_pkg::result_t      out_res
);

  logic                vld_r;
  logic                vld_nxt;
  tramon_pkg::result_t res_r;

  assign res_take  = res_valid && (!vld_r || out_ready);
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (res_take) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire
